>>> rtl/ecc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants of the edge convexity classifier
// Table depths, datapath widths, word codes and the multiply step list.
// ----------------------------------------------------------------------------
package ecc_pkg;

	// table depths and coordinate width
	localparam int VERTEX_DEPTH   = 4096;
	localparam int HALFEDGE_DEPTH = 16384;
	localparam int COORD_WIDTH    = 32;
	localparam int VA_W = $clog2(VERTEX_DEPTH);
	localparam int HA_W = $clog2(HALFEDGE_DEPTH);

	// field widths
	localparam int KIND_W = 2;
	localparam int VI_W   = 13;
	localparam int HI_W   = 15;
	localparam int TOL_W  = 16;
	localparam int POS_W  = 32;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;
	localparam int CLS_W  = 2;

	// table word widths, then datapath widths: differences, normal, dot product, norm, accumulator
	localparam int VW_W = 3 * COORD_WIDTH;
	localparam int HW_W = HI_W + VI_W;
	localparam int DW   = COORD_WIDTH + 1;
	localparam int NW   = 2 * DW + 1;
	localparam int DDW  = DW + NW + 2;
	localparam int NNW  = 2 * NW + 2;
	localparam int AW   = 2 * DDW + 1;

	// word kinds
	localparam logic [KIND_W-1:0] KIND_WR_VERTEX   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_HALFEDGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLASSIFY    = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_HALFEDGE_COUNT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FLAT_TOLERANCE = 2'd2;

	// result classes
	localparam logic [CLS_W-1:0] CLASS_UNKNOWN = 2'd0;
	localparam logic [CLS_W-1:0] CLASS_CONCAVE = 2'd1;
	localparam logic [CLS_W-1:0] CLASS_CONVEX  = 2'd2;
	localparam logic [CLS_W-1:0] CLASS_FLAT    = 2'd3;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_H, ST_RD_NX, ST_RD_PV, ST_RD_R, ST_WAIT_R, ST_VCHK,
		ST_RD_VA, ST_RD_VB, ST_RD_VC, ST_RD_VD, ST_WAIT_VD,
		ST_OP_GO, ST_OP_RUN, ST_DONE
	} state_t;

	// multiply-accumulate steps
	typedef enum logic [3:0] {
		OP_N0P, OP_N0M, OP_N1P, OP_N1M, OP_N2P, OP_N2M,
		OP_D0, OP_D1, OP_D2, OP_Q0, OP_Q1, OP_Q2,
		OP_TT, OP_RHS, OP_LHS
	} op_t;

	// command to the shared multiplier
	typedef struct packed {
		logic go;
		logic clr;
		logic sub;
	} mul_cmd_t;

endpackage

>>> rtl/ecc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_store: vertex and half-edge tables
// One write and one registered read port per table.
// ----------------------------------------------------------------------------
module ecc_store (
	input  logic                    clk,
	input  logic                    vwe,
	input  logic [ecc_pkg::VA_W-1:0] vwaddr,
	input  logic [ecc_pkg::VW_W-1:0] vwdata,
	input  logic [ecc_pkg::VA_W-1:0] vraddr,
	output logic [ecc_pkg::VW_W-1:0] vrdata,
	input  logic                    hwe,
	input  logic [ecc_pkg::HA_W-1:0] hwaddr,
	input  logic [ecc_pkg::HW_W-1:0] hwdata,
	input  logic [ecc_pkg::HA_W-1:0] hraddr,
	output logic [ecc_pkg::HW_W-1:0] hrdata
);
	import ecc_pkg::*;

	logic [VW_W-1:0] vmem [VERTEX_DEPTH];
	logic [HW_W-1:0] hmem [HALFEDGE_DEPTH];

	// vertex table
	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= vwdata;
		end
		vrdata <= vmem[vraddr];
	end

	// half-edge table
	always_ff @(posedge clk) begin
		if (hwe) begin
			hmem[hwaddr] <= hwdata;
		end
		hrdata <= hmem[hraddr];
	end

endmodule

>>> rtl/ecc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_mul: shared shift-add multiply-accumulate unit
// Adds or subtracts a*b into the accumulator, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ecc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ecc_pkg::mul_cmd_t             cmd,
	input  logic signed [ecc_pkg::AW-1:0] a,
	input  logic signed [ecc_pkg::AW-1:0] b,
	output logic                          run,
	output logic signed [ecc_pkg::AW-1:0] acc
);
	import ecc_pkg::*;

	logic              run_q;
	logic              neg_q;
	logic [AW-1:0]     ma_q;
	logic [AW-1:0]     mb_q;
	logic signed [AW-1:0] acc_q;

	// run flag drops once the multiplier bits are used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (cmd.go) begin
			run_q <= 1'b1;
		end else if (run_q && (mb_q == '0)) begin
			run_q <= 1'b0;
		end
	end

	// sign-magnitude shift-add step
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			ma_q  <= a[AW-1] ? $unsigned(-a) : $unsigned(a);
			mb_q  <= b[AW-1] ? $unsigned(-b) : $unsigned(b);
			neg_q <= a[AW-1] ^ b[AW-1] ^ cmd.sub;
			if (cmd.clr) begin
				acc_q <= '0;
			end
		end else if (run_q && (mb_q != '0)) begin
			if (mb_q[0]) begin
				acc_q <= neg_q ? acc_q - $signed(ma_q) : acc_q + $signed(ma_q);
			end
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign run = run_q;
	assign acc = acc_q;

endmodule

>>> rtl/mesh_edge_convexity_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_convexity_classifier: half-edge dihedral convexity test
// Table loading and classification of one half-edge per classify word.
// ----------------------------------------------------------------------------
// Write words (vertex or half-edge) leave busy low. A classify word raises
// busy for the dependent table reads and range checks, ST_RD_H through
// ST_WAIT_VD, then 15 multiply-accumulate steps on one shared shift-add
// unit. A step runs longer the more significant bits its multiplier
// magnitude has, so small coordinates finish sooner; an index that fails
// its range check ends early with unknown. The result word shows on
// edge_class for the single cycle that done is high and cannot be held off.
module mesh_edge_convexity_classifier (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [ecc_pkg::KIND_W-1:0]            kind,
	input  logic signed [ecc_pkg::HI_W-1:0]       index,
	input  logic signed [ecc_pkg::POS_W-1:0]      pos_x,
	input  logic signed [ecc_pkg::POS_W-1:0]      pos_y,
	input  logic signed [ecc_pkg::POS_W-1:0]      pos_z,
	input  logic signed [ecc_pkg::VI_W-1:0]       opposite_vertex,
	input  logic signed [ecc_pkg::HI_W-1:0]       reverse_edge,
	input  logic                                  cfg_we,
	input  logic [ecc_pkg::CIDX_W-1:0]            cfg_index,
	input  logic [ecc_pkg::CFG_W-1:0]             cfg_data,
	output logic                                  done,
	output logic [ecc_pkg::CLS_W-1:0]             edge_class
);
	import ecc_pkg::*;

	// residue mod 3 by folding base-4 digits
	function automatic logic [1:0] mod3(input logic [HI_W-1:0] x);
		logic [HI_W:0] xe;
		logic [4:0] s;
		logic [2:0] s2;
		logic [2:0] s3;
		xe = {1'b0, x};
		s = '0;
		for (int i = 0; i < HI_W; i += 2) begin
			s = s + 5'(xe[i +: 2]);
		end
		s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
	endfunction

	function automatic logic edge_ok(input logic [HI_W-1:0] e,
	                                 input logic [HI_W-1:0] cnt);
		logic [HI_W:0] e_w;
		e_w = {1'b0, e};
		return !e[HI_W-1] && (e < cnt) && (e_w < (HI_W+1)'(HALFEDGE_DEPTH));
	endfunction

	function automatic logic vert_ok(input logic [VI_W-1:0] v,
	                                 input logic [VI_W-1:0] cnt);
		logic [VI_W:0] v_w;
		v_w = {1'b0, v};
		return !v[VI_W-1] && (v < cnt) && (v_w < (VI_W+1)'(VERTEX_DEPTH));
	endfunction

	state_t state_q, state_d;
	op_t    op_q;

	logic [VI_W-1:0]  vertex_count_q;
	logic [HI_W-1:0]  halfedge_count_q;
	logic [TOL_W-1:0] flat_tolerance_q;

	logic [HI_W-1:0] h_q, nx_q, pv_q, r_q;
	logic [VI_W-1:0] vi_q [4];
	logic signed [COORD_WIDTH-1:0] pa_q [3];
	logic signed [DW-1:0]  ab_q [3];
	logic signed [DW-1:0]  ac_q [3];
	logic signed [DW-1:0]  ad_q [3];
	logic signed [NW-1:0]  n_q [3];
	logic signed [DDW-1:0] d_q;
	logic signed [NNW-1:0] nn_q;
	logic [2*TOL_W-1:0]    tt_q;
	logic signed [AW-1:0]  rhs_q;
	logic [CLS_W-1:0]      class_q;

	logic accept, accept_cls;
	logic [1:0] h_mod;
	logic [HI_W-1:0] nx_d, pv_d;
	logic h_good, r_good, v_good;

	logic [VA_W-1:0] vwaddr, vraddr;
	logic [HA_W-1:0] hwaddr, hraddr;
	logic [VW_W-1:0] vwdata, vrdata;
	logic [HW_W-1:0] hwdata, hrdata;
	logic vwe, hwe;
	logic signed [COORD_WIDTH-1:0] rd_c [3];
	logic [VI_W-1:0] rd_opp;
	logic [HI_W-1:0] rd_rev;

	mul_cmd_t mcmd;
	logic signed [AW-1:0] ma, mb, macc;
	logic mrun, op_done;

	// input decode and triangle neighbor edges
	assign accept     = start && !busy;
	assign accept_cls = accept && (kind == KIND_CLASSIFY);
	assign h_mod      = mod3($unsigned(index));
	assign nx_d = (h_mod == 2'd2) ? $unsigned(index) - HI_W'(2) : $unsigned(index) + HI_W'(1);
	assign pv_d = (h_mod == 2'd0) ? $unsigned(index) + HI_W'(2) : $unsigned(index) - HI_W'(1);
	assign h_good = edge_ok($unsigned(index), halfedge_count_q)
	             && edge_ok(nx_d, halfedge_count_q) && edge_ok(pv_d, halfedge_count_q);
	assign r_good = edge_ok(r_q, halfedge_count_q);
	assign v_good = vert_ok(vi_q[0], vertex_count_q) && vert_ok(vi_q[1], vertex_count_q)
	             && vert_ok(vi_q[2], vertex_count_q) && vert_ok(vi_q[3], vertex_count_q);
	assign op_done = (state_q == ST_OP_RUN) && !mrun;

	// table write path
	assign vwe    = accept && (kind == KIND_WR_VERTEX) && !index[HI_W-1]
	             && ($unsigned(index) < HI_W'(VERTEX_DEPTH));
	assign hwe    = accept && (kind == KIND_WR_HALFEDGE) && !index[HI_W-1]
	             && ({1'b0, $unsigned(index)} < (HI_W+1)'(HALFEDGE_DEPTH));
	assign vwaddr = index[VA_W-1:0];
	assign hwaddr = index[HA_W-1:0];
	assign vwdata = {pos_z[COORD_WIDTH-1:0], pos_y[COORD_WIDTH-1:0], pos_x[COORD_WIDTH-1:0]};
	assign hwdata = {reverse_edge, opposite_vertex};

	// read data fields
	assign rd_opp  = hrdata[VI_W-1:0];
	assign rd_rev  = hrdata[HW_W-1:VI_W];
	assign rd_c[0] = vrdata[COORD_WIDTH-1:0];
	assign rd_c[1] = vrdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign rd_c[2] = vrdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

	ecc_store u_store (
		.clk    (clk),
		.vwe    (vwe),
		.vwaddr (vwaddr),
		.vwdata (vwdata),
		.vraddr (vraddr),
		.vrdata (vrdata),
		.hwe    (hwe),
		.hwaddr (hwaddr),
		.hwdata (hwdata),
		.hraddr (hraddr),
		.hrdata (hrdata)
	);

	ecc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.a      (ma),
		.b      (mb),
		.run    (mrun),
		.acc    (macc)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q   <= '0;
			halfedge_count_q <= '0;
			flat_tolerance_q <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT:   vertex_count_q   <= cfg_data[VI_W-1:0];
				CFG_HALFEDGE_COUNT: halfedge_count_q <= cfg_data[HI_W-1:0];
				CFG_FLAT_TOLERANCE: flat_tolerance_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// state and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_N0P;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WAIT_VD) begin
				op_q <= OP_N0P;
			end else if (op_done && (op_q != OP_LHS)) begin
				op_q <= op_t'(op_q + 4'd1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept_cls) state_d = h_good ? ST_RD_H : ST_DONE;
			ST_RD_H:    state_d = ST_RD_NX;
			ST_RD_NX:   state_d = ST_RD_PV;
			ST_RD_PV:   state_d = ST_RD_R;
			ST_RD_R:    state_d = r_good ? ST_WAIT_R : ST_DONE;
			ST_WAIT_R:  state_d = ST_VCHK;
			ST_VCHK:    state_d = v_good ? ST_RD_VA : ST_DONE;
			ST_RD_VA:   state_d = ST_RD_VB;
			ST_RD_VB:   state_d = ST_RD_VC;
			ST_RD_VC:   state_d = ST_RD_VD;
			ST_RD_VD:   state_d = ST_WAIT_VD;
			ST_WAIT_VD: state_d = ST_OP_GO;
			ST_OP_GO:   state_d = ST_OP_RUN;
			ST_OP_RUN:  if (!mrun) state_d = (op_q == OP_LHS) ? ST_DONE : ST_OP_GO;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_DONE);
		edge_class = class_q;
		hraddr     = h_q[HA_W-1:0];
		vraddr     = vi_q[0][VA_W-1:0];
		mcmd       = '0;
		unique case (state_q)
			ST_RD_H:   hraddr = h_q[HA_W-1:0];
			ST_RD_NX:  hraddr = nx_q[HA_W-1:0];
			ST_RD_PV:  hraddr = pv_q[HA_W-1:0];
			ST_RD_R:   hraddr = r_q[HA_W-1:0];
			ST_RD_VA:  vraddr = vi_q[0][VA_W-1:0];
			ST_RD_VB:  vraddr = vi_q[1][VA_W-1:0];
			ST_RD_VC:  vraddr = vi_q[2][VA_W-1:0];
			ST_RD_VD:  vraddr = vi_q[3][VA_W-1:0];
			ST_OP_GO: begin
				mcmd.go  = 1'b1;
				mcmd.clr = (op_q == OP_N0P) || (op_q == OP_N1P) || (op_q == OP_N2P)
				        || (op_q == OP_D0) || (op_q == OP_Q0) || (op_q == OP_TT)
				        || (op_q == OP_RHS) || (op_q == OP_LHS);
				mcmd.sub = (op_q == OP_N0M) || (op_q == OP_N1M) || (op_q == OP_N2M);
			end
			default: ;
		endcase
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (op_q)
			OP_N0P: begin ma = AW'(ab_q[1]); mb = AW'(ac_q[2]); end
			OP_N0M: begin ma = AW'(ab_q[2]); mb = AW'(ac_q[1]); end
			OP_N1P: begin ma = AW'(ab_q[2]); mb = AW'(ac_q[0]); end
			OP_N1M: begin ma = AW'(ab_q[0]); mb = AW'(ac_q[2]); end
			OP_N2P: begin ma = AW'(ab_q[0]); mb = AW'(ac_q[1]); end
			OP_N2M: begin ma = AW'(ab_q[1]); mb = AW'(ac_q[0]); end
			OP_D0:  begin ma = AW'(n_q[0]); mb = AW'(ad_q[0]); end
			OP_D1:  begin ma = AW'(n_q[1]); mb = AW'(ad_q[1]); end
			OP_D2:  begin ma = AW'(n_q[2]); mb = AW'(ad_q[2]); end
			OP_Q0:  begin ma = AW'(n_q[0]); mb = AW'(n_q[0]); end
			OP_Q1:  begin ma = AW'(n_q[1]); mb = AW'(n_q[1]); end
			OP_Q2:  begin ma = AW'(n_q[2]); mb = AW'(n_q[2]); end
			OP_TT: begin
				ma = $signed({{(AW-TOL_W){1'b0}}, flat_tolerance_q});
				mb = $signed({{(AW-TOL_W){1'b0}}, flat_tolerance_q});
			end
			OP_RHS: begin ma = AW'(nn_q); mb = $signed({{(AW-2*TOL_W){1'b0}}, tt_q}); end
			OP_LHS: begin ma = AW'(d_q); mb = AW'(d_q); end
			default: ;
		endcase
	end

	// datapath captures
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				h_q     <= $unsigned(index);
				nx_q    <= nx_d;
				pv_q    <= pv_d;
				class_q <= CLASS_UNKNOWN;
			end
			ST_RD_NX: begin
				vi_q[2] <= rd_opp;
				r_q     <= rd_rev;
			end
			ST_RD_PV:  vi_q[0] <= rd_opp;
			ST_RD_R:   vi_q[1] <= rd_opp;
			ST_WAIT_R: vi_q[3] <= rd_opp;
			ST_RD_VB: begin
				for (int k = 0; k < 3; k++) pa_q[k] <= rd_c[k];
			end
			ST_RD_VC: begin
				for (int k = 0; k < 3; k++) ab_q[k] <= DW'(rd_c[k]) - DW'(pa_q[k]);
			end
			ST_RD_VD: begin
				for (int k = 0; k < 3; k++) ac_q[k] <= DW'(rd_c[k]) - DW'(pa_q[k]);
			end
			ST_WAIT_VD: begin
				for (int k = 0; k < 3; k++) ad_q[k] <= DW'(rd_c[k]) - DW'(pa_q[k]);
			end
			ST_OP_RUN: begin
				if (!mrun) begin
					unique case (op_q)
						OP_N0M: n_q[0] <= macc[NW-1:0];
						OP_N1M: n_q[1] <= macc[NW-1:0];
						OP_N2M: n_q[2] <= macc[NW-1:0];
						OP_D2:  d_q    <= macc[DDW-1:0];
						OP_Q2:  nn_q   <= macc[NNW-1:0];
						OP_TT:  tt_q   <= macc[2*TOL_W-1:0];
						OP_RHS: rhs_q  <= macc;
						OP_LHS: begin
							if ((d_q == '0) || !(macc > rhs_q)) begin
								class_q <= CLASS_FLAT;
							end else begin
								class_q <= d_q[DDW-1] ? CLASS_CONVEX : CLASS_CONCAVE;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a result word always closes a classify that was taken or under way
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || (start && (kind == KIND_CLASSIFY))))
		else $error("result word without a classify in progress");

	// a classify word makes the block busy
	a_cls_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_CLASSIFY)) |=> busy)
		else $error("classify word not taken up");

	// the block frees up right after a result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result word");
`endif

endmodule
